// File: hw/rtl/sgi_pkg.sv
package sgi_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int IN_BITS        = 32;
    localparam int HIT_BITS       = 32;
    localparam int FRAC_BITS      = 16;
    localparam int PAR_SHIFT      = 20;

    typedef enum logic [1:0] {
        OC_NONE = 2'd0,
        OC_ONE  = 2'd1,
        OC_COL  = 2'd2
    } outcome_t;

endpackage

// File: hw/rtl/segment_intersect_2d.sv
// Segment pair intersection in the XY plane, fully pipelined: one transaction can enter
// every cycle. The pipeline depth is set by the restoring divider for s, which resolves
// one quotient bit per stage, and by the near-parallel test, whose wide squared products
// are built from half-width partial products over two stages. The whole pipeline holds
// while the output register carries a transaction and out_stall is high; otherwise
// in_stall stays low and a new transaction is taken every cycle.
module segment_intersect_2d
    import sgi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [IN_BITS-1:0]   a_start_x,
    input  logic signed [IN_BITS-1:0]   a_start_y,
    input  logic signed [IN_BITS-1:0]   a_start_z,
    input  logic signed [IN_BITS-1:0]   a_end_x,
    input  logic signed [IN_BITS-1:0]   a_end_y,
    input  logic signed [IN_BITS-1:0]   a_end_z,
    input  logic signed [IN_BITS-1:0]   b_start_x,
    input  logic signed [IN_BITS-1:0]   b_start_y,
    input  logic signed [IN_BITS-1:0]   b_end_x,
    input  logic signed [IN_BITS-1:0]   b_end_y,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  outcome,
    output logic signed [HIT_BITS-1:0]  hit_x,
    output logic signed [HIT_BITS-1:0]  hit_y,
    output logic signed [HIT_BITS-1:0]  hit_z,
    output logic [FRAC_BITS:0]          fraction
);

    localparam int W   = COORD_BITS;
    localparam int XW  = (W > IN_BITS) ? W : IN_BITS;
    localparam int D   = W + 1;
    localparam int PW  = 2 * D;
    localparam int KW  = PW + 1;
    localparam int MW  = PW;
    localparam int HL  = (MW + 1) / 2;
    localparam int HH  = MW - HL;
    localparam int BW  = 2 * MW;
    localparam int CW  = BW + PAR_SHIFT;
    localparam int RW  = MW + 1;
    localparam int FB  = FRAC_BITS;
    localparam int FW  = FB + 1;
    localparam int MPW = FW + 1 + D;
    localparam int OW  = (MPW > HIT_BITS) ? MPW : HIT_BITS;
    localparam int NS  = 6 + FB + 2;
    localparam int S6  = 5;
    localparam int SM  = 6 + FB;

    typedef struct packed {
        logic signed [W-1:0] x0;
        logic signed [W-1:0] y0;
        logic signed [W-1:0] z0;
        logic signed [D-1:0] dx0;
        logic signed [D-1:0] dy0;
        logic signed [D-1:0] dz;
    } geo_t;

    typedef struct packed {
        geo_t                geo;
        logic signed [D-1:0] dx1;
        logic signed [D-1:0] dy1;
        logic signed [D-1:0] sx;
        logic signed [D-1:0] sy;
    } s1_t;

    typedef struct packed {
        geo_t                 geo;
        logic signed [PW-1:0] kra;
        logic signed [PW-1:0] krb;
        logic signed [PW-1:0] l0a;
        logic signed [PW-1:0] l0b;
        logic signed [PW-1:0] l1a;
        logic signed [PW-1:0] l1b;
        logic signed [PW-1:0] nsa;
        logic signed [PW-1:0] nsb;
        logic signed [PW-1:0] nta;
        logic signed [PW-1:0] ntb;
        logic signed [PW-1:0] lsa;
        logic signed [PW-1:0] lsb;
    } s2_t;

    typedef struct packed {
        geo_t                 geo;
        logic                 krneg;
        logic [MW-1:0]        akr;
        logic [MW-1:0]        ant;
        logic [MW-1:0]        l0;
        logic [MW-1:0]        l1;
        logic [MW-1:0]        ls;
        logic signed [KW-1:0] ns;
        logic signed [KW-1:0] nt;
    } s3_t;

    typedef struct packed {
        logic [2*HL-1:0]  ll;
        logic [HL+HH-1:0] lh;
        logic [HL+HH-1:0] hl;
        logic [2*HH-1:0]  hh;
    } pp_t;

    typedef struct packed {
        geo_t                 geo;
        logic                 krneg;
        logic [MW-1:0]        akr;
        logic signed [KW-1:0] ns;
        logic signed [KW-1:0] nt;
        pp_t                  pkk;
        pp_t                  pll;
        pp_t                  pnn;
        pp_t                  pls;
    } s4_t;

    typedef struct packed {
        geo_t                 geo;
        logic                 krneg;
        logic [MW-1:0]        akr;
        logic signed [KW-1:0] ns;
        logic signed [KW-1:0] nt;
        logic [BW-1:0]        kk;
        logic [BW-1:0]        ll;
        logic [BW-1:0]        nn;
        logic [BW-1:0]        lls;
    } s5_t;

    typedef struct packed {
        geo_t          geo;
        outcome_t      oc;
        logic          sat;
        logic [RW-1:0] rem;
        logic [MW-1:0] den;
        logic [FB-1:0] q;
    } dv_t;

    typedef struct packed {
        logic signed [W-1:0]   x0;
        logic signed [W-1:0]   y0;
        logic signed [W-1:0]   z0;
        outcome_t              oc;
        logic [FW-1:0]         f;
        logic signed [MPW-1:0] mx;
        logic signed [MPW-1:0] my;
        logic signed [MPW-1:0] mz;
    } m_t;

    function automatic logic signed [W-1:0] to_coord(input logic signed [IN_BITS-1:0] v);
        logic [XW-1:0] e;
        e = XW'($unsigned(v));
        return e[W-1:0];
    endfunction

    function automatic logic signed [PW-1:0] mul_d(input logic signed [D-1:0] a,
                                                   input logic signed [D-1:0] b);
        return PW'(a) * PW'(b);
    endfunction

    function automatic pp_t pp_split(input logic [MW-1:0] a, input logic [MW-1:0] b);
        pp_t r;
        r.ll = (2*HL)'(a[HL-1:0]) * (2*HL)'(b[HL-1:0]);
        r.lh = (HL+HH)'(a[HL-1:0]) * (HL+HH)'(b[MW-1:HL]);
        r.hl = (HL+HH)'(a[MW-1:HL]) * (HL+HH)'(b[HL-1:0]);
        r.hh = (2*HH)'(a[MW-1:HL]) * (2*HH)'(b[MW-1:HL]);
        return r;
    endfunction

    function automatic logic [BW-1:0] pp_sum(input pp_t p);
        return (BW'(p.hh) << (2*HL)) + ((BW'(p.lh) + BW'(p.hl)) << HL) + BW'(p.ll);
    endfunction

    logic             adv;
    logic [NS-1:0]    v_reg;
    s1_t              s1_reg, s1_next;
    s2_t              s2_reg, s2_next;
    s3_t              s3_reg, s3_next;
    s4_t              s4_reg, s4_next;
    s5_t              s5_reg, s5_next;
    dv_t              s6_reg, s6_next;
    dv_t              dv_reg  [FB];
    dv_t              dv_next [FB];
    m_t               m_reg, m_next;
    outcome_t         oc_reg, oc_next;
    logic signed [HIT_BITS-1:0] hx_reg, hx_next;
    logic signed [HIT_BITS-1:0] hy_reg, hy_next;
    logic signed [HIT_BITS-1:0] hz_reg, hz_next;
    logic [FW-1:0]    fr_reg, fr_next;

    // hold everything while the output transaction waits
    assign adv      = !(v_reg[NS-1] && out_stall);
    assign in_stall = !adv;

    always_comb
    begin
        logic signed [W-1:0] x1, y1, z1, x2, y2, x3, y3;
        x1 = to_coord(a_end_x);
        y1 = to_coord(a_end_y);
        z1 = to_coord(a_end_z);
        x2 = to_coord(b_start_x);
        y2 = to_coord(b_start_y);
        x3 = to_coord(b_end_x);
        y3 = to_coord(b_end_y);
        s1_next.geo.x0  = to_coord(a_start_x);
        s1_next.geo.y0  = to_coord(a_start_y);
        s1_next.geo.z0  = to_coord(a_start_z);
        s1_next.geo.dx0 = D'(x1) - D'(s1_next.geo.x0);
        s1_next.geo.dy0 = D'(y1) - D'(s1_next.geo.y0);
        s1_next.geo.dz  = D'(z1) - D'(s1_next.geo.z0);
        s1_next.dx1     = D'(x3) - D'(x2);
        s1_next.dy1     = D'(y3) - D'(y2);
        s1_next.sx      = D'(x2) - D'(s1_next.geo.x0);
        s1_next.sy      = D'(y2) - D'(s1_next.geo.y0);
    end

    always_comb
    begin
        s2_next.geo = s1_reg.geo;
        s2_next.kra = mul_d(s1_reg.geo.dx0, s1_reg.dy1);
        s2_next.krb = mul_d(s1_reg.geo.dy0, s1_reg.dx1);
        s2_next.l0a = mul_d(s1_reg.geo.dx0, s1_reg.geo.dx0);
        s2_next.l0b = mul_d(s1_reg.geo.dy0, s1_reg.geo.dy0);
        s2_next.l1a = mul_d(s1_reg.dx1, s1_reg.dx1);
        s2_next.l1b = mul_d(s1_reg.dy1, s1_reg.dy1);
        s2_next.nsa = mul_d(s1_reg.sx, s1_reg.dy1);
        s2_next.nsb = mul_d(s1_reg.sy, s1_reg.dx1);
        s2_next.nta = mul_d(s1_reg.sx, s1_reg.geo.dy0);
        s2_next.ntb = mul_d(s1_reg.sy, s1_reg.geo.dx0);
        s2_next.lsa = mul_d(s1_reg.sx, s1_reg.sx);
        s2_next.lsb = mul_d(s1_reg.sy, s1_reg.sy);
    end

    always_comb
    begin
        logic signed [KW-1:0] kr;
        logic signed [KW-1:0] krm;
        logic signed [KW-1:0] ntm;
        kr  = KW'(s2_reg.kra) - KW'(s2_reg.krb);
        krm = -kr;
        s3_next.geo   = s2_reg.geo;
        s3_next.krneg = kr[KW-1];
        s3_next.akr   = kr[KW-1] ? krm[MW-1:0] : kr[MW-1:0];
        s3_next.ns    = KW'(s2_reg.nsa) - KW'(s2_reg.nsb);
        s3_next.nt    = KW'(s2_reg.nta) - KW'(s2_reg.ntb);
        ntm           = -s3_next.nt;
        s3_next.ant   = s3_next.nt[KW-1] ? ntm[MW-1:0] : s3_next.nt[MW-1:0];
        s3_next.l0    = MW'(s2_reg.l0a) + MW'(s2_reg.l0b);
        s3_next.l1    = MW'(s2_reg.l1a) + MW'(s2_reg.l1b);
        s3_next.ls    = MW'(s2_reg.lsa) + MW'(s2_reg.lsb);
    end

    always_comb
    begin
        s4_next.geo   = s3_reg.geo;
        s4_next.krneg = s3_reg.krneg;
        s4_next.akr   = s3_reg.akr;
        s4_next.ns    = s3_reg.ns;
        s4_next.nt    = s3_reg.nt;
        s4_next.pkk   = pp_split(s3_reg.akr, s3_reg.akr);
        s4_next.pll   = pp_split(s3_reg.l0, s3_reg.l1);
        s4_next.pnn   = pp_split(s3_reg.ant, s3_reg.ant);
        s4_next.pls   = pp_split(s3_reg.l0, s3_reg.ls);
    end

    always_comb
    begin
        s5_next.geo   = s4_reg.geo;
        s5_next.krneg = s4_reg.krneg;
        s5_next.akr   = s4_reg.akr;
        s5_next.ns    = s4_reg.ns;
        s5_next.nt    = s4_reg.nt;
        s5_next.kk    = pp_sum(s4_reg.pkk);
        s5_next.ll    = pp_sum(s4_reg.pll);
        s5_next.nn    = pp_sum(s4_reg.pnn);
        s5_next.lls   = pp_sum(s4_reg.pls);
    end

    // classify and fold the sign of the cross product into both numerators
    always_comb
    begin
        logic                 np;
        logic                 far;
        logic                 inr;
        logic signed [KW-1:0] nsn;
        logic signed [KW-1:0] ntn;
        np  = (CW'(s5_reg.kk) << PAR_SHIFT) > CW'(s5_reg.ll);
        far = (CW'(s5_reg.nn) << PAR_SHIFT) > CW'(s5_reg.lls);
        nsn = s5_reg.krneg ? -s5_reg.ns : s5_reg.ns;
        ntn = s5_reg.krneg ? -s5_reg.nt : s5_reg.nt;
        inr = !nsn[KW-1] && !ntn[KW-1]
              && ($unsigned(nsn) <= KW'(s5_reg.akr))
              && ($unsigned(ntn) <= KW'(s5_reg.akr));
        s6_next.geo = s5_reg.geo;
        if (np)
        begin
            s6_next.oc = inr ? OC_ONE : OC_NONE;
        end
        else
        begin
            s6_next.oc = far ? OC_NONE : OC_COL;
        end
        s6_next.sat = (nsn[MW-1:0] == s5_reg.akr);
        s6_next.rem = RW'(nsn[MW-1:0]);
        s6_next.den = s5_reg.akr;
        s6_next.q   = '0;
    end

    // restoring divider, one quotient bit per stage
    always_comb
    begin
        dv_t           src;
        logic [RW-1:0] t;
        logic          ge;
        for (int i = 0; i < FB; i++)
        begin
            src        = (i == 0) ? s6_reg : dv_reg[(i == 0) ? 0 : i - 1];
            t          = {src.rem[RW-2:0], 1'b0};
            ge         = t >= RW'(src.den);
            dv_next[i] = src;
            dv_next[i].rem = ge ? t - RW'(src.den) : t;
            dv_next[i].q   = {src.q[FB-2:0], ge};
        end
    end

    always_comb
    begin
        dv_t last;
        last        = dv_reg[FB-1];
        m_next.x0   = last.geo.x0;
        m_next.y0   = last.geo.y0;
        m_next.z0   = last.geo.z0;
        m_next.oc   = last.oc;
        m_next.f    = last.sat ? FW'(1 << FB) : FW'(last.q);
        m_next.mx   = MPW'(signed'({1'b0, m_next.f})) * MPW'(last.geo.dx0);
        m_next.my   = MPW'(signed'({1'b0, m_next.f})) * MPW'(last.geo.dy0);
        m_next.mz   = MPW'(signed'({1'b0, m_next.f})) * MPW'(last.geo.dz);
    end

    always_comb
    begin
        logic signed [OW-1:0] px, py, pz;
        px = OW'(m_reg.x0) + OW'(m_reg.mx >>> FB);
        py = OW'(m_reg.y0) + OW'(m_reg.my >>> FB);
        pz = OW'(m_reg.z0) + OW'(m_reg.mz >>> FB);
        oc_next = m_reg.oc;
        if (m_reg.oc == OC_ONE)
        begin
            hx_next = px[HIT_BITS-1:0];
            hy_next = py[HIT_BITS-1:0];
            hz_next = pz[HIT_BITS-1:0];
            fr_next = m_reg.f;
        end
        else
        begin
            hx_next = '0;
            hy_next = '0;
            hz_next = '0;
            fr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
            for (int i = 0; i < FB; i++)
            begin
                dv_reg[i] <= dv_next[i];
            end
            m_reg  <= m_next;
            oc_reg <= oc_next;
            hx_reg <= hx_next;
            hy_reg <= hy_next;
            hz_reg <= hz_next;
            fr_reg <= fr_next;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign outcome   = oc_reg;
    assign hit_x     = hx_reg;
    assign hit_y     = hy_reg;
    assign hit_z     = hz_reg;
    assign fraction  = fr_reg;

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[S6] && s6_reg.oc == OC_ONE) |-> (s6_reg.den != '0))
        else $error("single point classified with zero cross product");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outcome != OC_ONE) |->
            (hit_x == '0 && hit_y == '0 && hit_z == '0 && fraction == '0))
        else $error("result fields not cleared for a non-point outcome");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[SM] && m_reg.oc == OC_ONE) |-> (m_reg.f <= FW'(1 << FB)))
        else $error("fraction above one");

    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outcome == OC_NONE || outcome == OC_ONE || outcome == OC_COL))
        else $error("reserved outcome code");

endmodule
